// ===== design/vdt_pkg.sv =====
// vdt_pkg: shared types and constants of the vertex dedup table.
// Used by vdt_cell, vdt_near and vertex_dedup_table; no dependencies.
`timescale 1ns / 1ps

package vdt_pkg;

   // Field widths fixed by the interface
   localparam int COORD_W   = 48;           // signed Q31.16 coordinate
   localparam int DIFF_W    = COORD_W + 1;  // exact coordinate difference
   localparam int MAG_W     = 20;           // magnitudes at or above 2^20 never match
   localparam int SQ_W      = 2 * MAG_W;    // one squared magnitude
   localparam int THR_W     = 40;           // squared distance limit, Q.32
   localparam int OUT_IDX_W = 8;            // reported vertex index

   localparam logic [THR_W-1:0] THR_RESET = 40'd4295;  // 1e-6 in Q.32

   // Distance unit depth, cycles from issue to result
   localparam int NEAR_LAT = 3;
   localparam int DRAIN_W  = $clog2(NEAR_LAT);

   // Transaction kinds
   localparam logic KIND_FIND  = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // Control shared by every cell of the ring
   typedef struct packed {
      logic shift;   // rotate ring one place toward the head
      logic load;    // store the query point in the selected cell
   } cell_ctl_type;

endpackage

// ===== design/vdt_cell.sv =====
// vdt_cell: one slot of the vertex ring, holds one stored point.
// Depends on vdt_pkg for coordinate width and the cell control struct.
`timescale 1ns / 1ps

module vdt_cell (
   input  logic                                clock,
   input  vdt_pkg::cell_ctl_type               ctl,
   input  logic                                sel,
   input  logic signed [vdt_pkg::COORD_W-1:0]  next_x,
   input  logic signed [vdt_pkg::COORD_W-1:0]  next_y,
   input  logic signed [vdt_pkg::COORD_W-1:0]  load_x,
   input  logic signed [vdt_pkg::COORD_W-1:0]  load_y,
   output logic signed [vdt_pkg::COORD_W-1:0]  point_x,
   output logic signed [vdt_pkg::COORD_W-1:0]  point_y
);
   import vdt_pkg::*;

   logic signed [COORD_W-1:0] x_ff, x_in;
   logic signed [COORD_W-1:0] y_ff, y_in;

   // Append has priority; otherwise take the neighbor's point while rotating
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (ctl.load && sel) begin
         x_in = load_x;
         y_in = load_y;
      end else if (ctl.shift) begin
         x_in = next_x;
         y_in = next_y;
      end
   end

   // Payload only, no reset
   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign point_x = x_ff;
   assign point_y = y_ff;

endmodule

// ===== design/vdt_near.sv =====
// vdt_near: three-stage squared distance compare of query against one vertex.
// Depends on vdt_pkg for widths.
`timescale 1ns / 1ps

module vdt_near #(
   parameter int IDX_W = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic [IDX_W-1:0]                    in_idx,
   input  logic signed [vdt_pkg::COORD_W-1:0]  query_x,
   input  logic signed [vdt_pkg::COORD_W-1:0]  query_y,
   input  logic signed [vdt_pkg::COORD_W-1:0]  vert_x,
   input  logic signed [vdt_pkg::COORD_W-1:0]  vert_y,
   input  logic [vdt_pkg::THR_W-1:0]           threshold,
   output logic                                out_valid,
   output logic [IDX_W-1:0]                    out_idx,
   output logic                                out_near
);
   import vdt_pkg::*;

   // Stage 1: exact differences and magnitudes
   logic signed [DIFF_W-1:0] dx, dy;
   logic [DIFF_W-1:0]        mag_x, mag_y;
   logic                     big_in;

   assign dx     = {query_x[COORD_W-1], query_x} - {vert_x[COORD_W-1], vert_x};
   assign dy     = {query_y[COORD_W-1], query_y} - {vert_y[COORD_W-1], vert_y};
   assign mag_x  = dx[DIFF_W-1] ? (~dx + 1'b1) : dx;
   assign mag_y  = dy[DIFF_W-1] ? (~dy + 1'b1) : dy;
   assign big_in = (|mag_x[DIFF_W-1:MAG_W]) | (|mag_y[DIFF_W-1:MAG_W]);

   logic             v1_ff;
   logic [IDX_W-1:0] idx1_ff;
   logic [MAG_W-1:0] ax_ff, ay_ff;
   logic             big1_ff;

   // Stage 2: squares
   logic [SQ_W-1:0]  sqx_in, sqy_in;
   logic             v2_ff;
   logic [IDX_W-1:0] idx2_ff;
   logic [SQ_W-1:0]  sqx_ff, sqy_ff;
   logic             big2_ff;

   assign sqx_in = SQ_W'(ax_ff) * SQ_W'(ax_ff);
   assign sqy_in = SQ_W'(ay_ff) * SQ_W'(ay_ff);

   // Stage 3: sum and compare
   logic [SQ_W:0]    sum;
   logic             near_in;
   logic             v3_ff;
   logic [IDX_W-1:0] idx3_ff;
   logic             near3_ff;

   assign sum     = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign near_in = !big2_ff && (sum < {1'b0, threshold});

   // Valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      idx1_ff  <= in_idx;
      ax_ff    <= mag_x[MAG_W-1:0];
      ay_ff    <= mag_y[MAG_W-1:0];
      big1_ff  <= big_in;
      idx2_ff  <= idx1_ff;
      sqx_ff   <= sqx_in;
      sqy_ff   <= sqy_in;
      big2_ff  <= big1_ff;
      idx3_ff  <= idx2_ff;
      near3_ff <= near_in;
   end

   assign out_valid = v3_ff;
   assign out_idx   = idx3_ff;
   assign out_near  = near3_ff;

endmodule

// ===== design/vertex_dedup_table.sv =====
// vertex_dedup_table: top level, ring of vertex cells plus one distance unit.
// Depends on vdt_pkg, vdt_cell and vdt_near.
`timescale 1ns / 1ps

// Usage
//   Request: drive req_kind/req_point_x/req_point_y with start high; the
//   transaction is taken at the edge where start is high and busy is low.
//   A clear transaction empties the table and answers on the next cycle with
//   index 0; busy does not rise for it.
//   A find transaction rotates the stored vertices once around the ring past
//   the single distance unit, oldest first, then appends or reports. It goes
//   through a scan over every ring slot, a drain of the three-stage distance
//   pipeline and a decision state. busy is high through the scan, drain and
//   decision states.
//   Response: rsp_valid is high for exactly one cycle with rsp_vertex_index,
//   rsp_was_found and rsp_table_full; there is no back pressure, the
//   receiver must take it in that cycle.
//   Config: csr_write_en with csr_write_data sets the squared distance limit;
//   write only while idle.
//   Reset: synchronous, clears the vertex count and restores the limit to
//   4295 (1e-6 in Q.32). Stored points are not cleared; they are never read
//   before being written.
module vertex_dedup_table #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_kind,
   input  logic signed [vdt_pkg::COORD_W-1:0]  req_point_x,
   input  logic signed [vdt_pkg::COORD_W-1:0]  req_point_y,
   output logic                                rsp_valid,
   output logic [vdt_pkg::OUT_IDX_W-1:0]       rsp_vertex_index,
   output logic                                rsp_was_found,
   output logic                                rsp_table_full,
   input  logic                                csr_write_en,
   input  logic [vdt_pkg::THR_W-1:0]           csr_write_data
);
   import vdt_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = IDX_W + 1;
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
   localparam logic [DRAIN_W-1:0] LAST_DRAIN = DRAIN_W'(NEAR_LAT - 1);

   // Control and data registers
   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      slot_ff, slot_in;
   logic [DRAIN_W-1:0]    drain_ff, drain_in;
   logic                  hit_ff, hit_in;
   logic [IDX_W-1:0]      hit_idx_ff, hit_idx_in;
   logic [THR_W-1:0]      thr_ff, thr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic                  rsp_full_ff, rsp_full_in;
   logic signed [COORD_W-1:0] qx_ff, qx_in;
   logic signed [COORD_W-1:0] qy_ff, qy_in;

   logic                  accept;
   cell_ctl_type          ctl;
   logic                  issue_valid;
   logic                  near_valid;
   logic [IDX_W-1:0]      near_idx;
   logic                  near_hit;

   // Vertex ring: slot 0 is the head, each slot takes its upper neighbor
   logic signed [COORD_W-1:0] cell_x [TABLE_DEPTH];
   logic signed [COORD_W-1:0] cell_y [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]    cell_sel;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_ring
      assign cell_sel[i] = (count_ff[IDX_W-1:0] == IDX_W'(i));

      vdt_cell u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .sel     (cell_sel[i]),
         .next_x  (cell_x[(i + 1) % TABLE_DEPTH]),
         .next_y  (cell_y[(i + 1) % TABLE_DEPTH]),
         .load_x  (qx_ff),
         .load_y  (qy_ff),
         .point_x (cell_x[i]),
         .point_y (cell_y[i])
      );
   end

   // Distance unit looks at the head slot; only live entries are issued
   assign issue_valid = (state_ff == ST_SCAN) && ({1'b0, slot_ff} < count_ff);

   vdt_near #(
      .IDX_W (IDX_W)
   ) u_near (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (issue_valid),
      .in_idx    (slot_ff),
      .query_x   (qx_ff),
      .query_y   (qy_ff),
      .vert_x    (cell_x[0]),
      .vert_y    (cell_y[0]),
      .threshold (thr_ff),
      .out_valid (near_valid),
      .out_idx   (near_idx),
      .out_near  (near_hit)
   );

   assign accept = start && !busy;

   // Next state and outputs
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      slot_in      = slot_ff;
      drain_in     = drain_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      rsp_valid_in = 1'b0;
      rsp_idx_in   = rsp_idx_ff;
      rsp_found_in = rsp_found_ff;
      rsp_full_in  = rsp_full_ff;
      ctl.shift    = 1'b0;
      ctl.load     = 1'b0;
      thr_in       = csr_write_en ? csr_write_data : thr_ff;

      // First match in scan order wins
      if (near_valid && near_hit && !hit_ff) begin
         hit_in     = 1'b1;
         hit_idx_in = near_idx;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_CLEAR) begin
                  count_in     = '0;
                  rsp_valid_in = 1'b1;
                  rsp_idx_in   = '0;
                  rsp_found_in = 1'b0;
                  rsp_full_in  = 1'b0;
               end else begin
                  qx_in    = req_point_x;
                  qy_in    = req_point_y;
                  slot_in  = '0;
                  hit_in   = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            ctl.shift = 1'b1;
            slot_in   = slot_ff + 1'b1;
            if (slot_ff == LAST_SLOT) begin
               drain_in = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + 1'b1;
            if (drain_ff == LAST_DRAIN) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (hit_ff) begin
               rsp_idx_in   = OUT_IDX_W'(hit_idx_ff);
               rsp_found_in = 1'b1;
               rsp_full_in  = 1'b0;
            end else if (count_ff < DEPTH_CNT) begin
               ctl.load     = 1'b1;
               count_in     = count_ff + 1'b1;
               rsp_idx_in   = OUT_IDX_W'(count_ff);
               rsp_found_in = 1'b0;
               rsp_full_in  = 1'b0;
            end else begin
               rsp_idx_in   = '0;
               rsp_found_in = 1'b0;
               rsp_full_in  = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= THR_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
         thr_ff       <= thr_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      drain_ff     <= drain_in;
      hit_idx_ff   <= hit_idx_in;
      qx_ff        <= qx_in;
      qy_ff        <= qy_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_found_ff <= rsp_found_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_index = rsp_idx_ff;
   assign rsp_was_found    = rsp_found_ff;
   assign rsp_table_full   = rsp_full_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("vertex count above table depth");

   a_found_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_found |-> !rsp_table_full)
      else $error("response both found and full");

   a_hit_live: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && hit_ff |-> {1'b0, hit_idx_ff} < count_ff)
      else $error("match on an entry that was never written");

   a_find_busy: assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == KIND_FIND |=> busy && !rsp_valid)
      else $error("find transaction did not start a scan");

   a_near_in_scan: assert property (@(posedge clock) disable iff (reset)
      near_valid |-> state_ff == ST_SCAN || state_ff == ST_DRAIN)
      else $error("distance result outside a scan");

endmodule

// ===== test/vertex_dedup_table_test.sv =====
// vertex_dedup_table_test: self-checking testbench for the vertex dedup table.
// Predicts each lookup with its own copy of the vertex store; depends on vdt_pkg
// and vertex_dedup_table.
`timescale 1ns / 1ps

module vertex_dedup_table_test;
   import vdt_pkg::*;

   localparam int TABLE_DEPTH    = 256;
   localparam int WATCHDOG_LIMIT = 4000;            // quiet cycles before giving up
   localparam int DRAIN_CYCLES   = TABLE_DEPTH + 40; // settle time after the last result
   localparam logic [THR_W-1:0] THR_MAX = '1;

   typedef struct packed {
      logic               kind;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } lookup_req_type;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] index;
      logic                 found;
      logic                 full;
   } lookup_rsp_type;

   // DUT signals
   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic                        req_kind = KIND_FIND;
   logic signed [COORD_W-1:0]   req_point_x = '0;
   logic signed [COORD_W-1:0]   req_point_y = '0;
   logic                        rsp_valid;
   logic [OUT_IDX_W-1:0]        rsp_vertex_index;
   logic                        rsp_was_found;
   logic                        rsp_table_full;
   logic                        csr_write_en = 1'b0;
   logic [THR_W-1:0]            csr_write_data = '0;

   // Testbench state
   lookup_req_type pending_lookups[$];
   lookup_rsp_type lookup_expect[$];
   lookup_req_type offered;
   logic [COORD_W-1:0] seen_x[$];
   logic [COORD_W-1:0] seen_y[$];
   int idle_pct = 0;
   int fail_count = 0;
   int quiet_cycles = 0;

   // Predicted vertex store and distance limit
   logic [COORD_W-1:0] vtx_x[TABLE_DEPTH];
   logic [COORD_W-1:0] vtx_y[TABLE_DEPTH];
   int vtx_count = 0;
   logic [THR_W-1:0] near_limit = THR_RESET;

   always #5 clock = ~clock;

   vertex_dedup_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_point_x(req_point_x),
      .req_point_y(req_point_y),
      .rsp_valid(rsp_valid),
      .rsp_vertex_index(rsp_vertex_index),
      .rsp_was_found(rsp_was_found),
      .rsp_table_full(rsp_table_full),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data)
   );

   // Exact squared distance test; large differences never match
   function automatic bit vertex_is_near(input logic [COORD_W-1:0] px, py, ux, uy);
      logic [DIFF_W-1:0] dx, dy, mx, my;
      logic [SQ_W:0] sx, sy;
      dx = {px[COORD_W-1], px} - {ux[COORD_W-1], ux};
      dy = {py[COORD_W-1], py} - {uy[COORD_W-1], uy};
      mx = dx[DIFF_W-1] ? (~dx + 1'b1) : dx;
      my = dy[DIFF_W-1] ? (~dy + 1'b1) : dy;
      if (mx[DIFF_W-1:MAG_W] != '0 || my[DIFF_W-1:MAG_W] != '0)
         return 1'b0;
      sx = (SQ_W + 1)'(mx[MAG_W-1:0]);
      sy = (SQ_W + 1)'(my[MAG_W-1:0]);
      sx = sx * sx;
      sy = sy * sy;
      return (sx + sy) < {1'b0, near_limit};
   endfunction

   // Find-or-add against the predicted store, updating it
   function automatic lookup_rsp_type weld_lookup(input lookup_req_type r);
      lookup_rsp_type res;
      bit hit;
      int i;
      res = '0;
      hit = 1'b0;
      if (r.kind == KIND_CLEAR) begin
         vtx_count = 0;
         return res;
      end
      for (i = 0; i < vtx_count && !hit; i++) begin
         if (vertex_is_near(r.x, r.y, vtx_x[i], vtx_y[i])) begin
            hit = 1'b1;
            res.index = i[OUT_IDX_W-1:0];
            res.found = 1'b1;
         end
      end
      if (!hit) begin
         if (vtx_count < TABLE_DEPTH) begin
            vtx_x[vtx_count] = r.x;
            vtx_y[vtx_count] = r.y;
            res.index = vtx_count[OUT_IDX_W-1:0];
            vtx_count++;
         end else begin
            res.full = 1'b1;
         end
      end
      return res;
   endfunction

   function automatic logic [COORD_W-1:0] rand48();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[COORD_W-1:0];
   endfunction

   // Offset around a known point: mostly small, sometimes right at the 2^20 cutoff
   function automatic logic [COORD_W-1:0] rand_offset();
      logic [COORD_W-1:0] m;
      int e;
      e = $urandom_range(0, MAG_W + 1);
      case ($urandom_range(0, 9))
         0: m = 48'h10_0000;
         1: m = 48'h0F_FFFF;
         default: m = COORD_W'($urandom_range(0, 1 << e));
      endcase
      if ($urandom_range(0, 1))
         m = -m;
      return m;
   endfunction

   task automatic push_find(input logic [COORD_W-1:0] x, y);
      lookup_req_type r;
      r.kind = KIND_FIND;
      r.x = x;
      r.y = y;
      pending_lookups.insert(pending_lookups.size(), r);
      seen_x.insert(seen_x.size(), x);
      seen_y.insert(seen_y.size(), y);
      if (seen_x.size() > TABLE_DEPTH) begin
         void'(seen_x.pop_front());
         void'(seen_y.pop_front());
      end
   endtask

   task automatic push_clear(input logic [COORD_W-1:0] x, y);
      lookup_req_type r;
      r.kind = KIND_CLEAR;
      r.x = x;
      r.y = y;
      pending_lookups.insert(pending_lookups.size(), r);
   endtask

   // Random transactions: clears, points near earlier ones, and wide random points
   task automatic gen_lookups(input int count, input int clear_pct, input int near_pct);
      int n;
      int pick;
      for (n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < clear_pct) begin
            push_clear(rand48(), rand48());
         end else if (seen_x.size() != 0 && $urandom_range(0, 99) < near_pct) begin
            pick = $urandom_range(0, seen_x.size() - 1);
            push_find(seen_x[pick] + rand_offset(), seen_y[pick] + rand_offset());
         end else begin
            push_find(rand48(), rand48());
         end
      end
   endtask

   // Wait until every transaction is taken and answered
   task automatic wait_idle();
      while (pending_lookups.size() != 0 || lookup_expect.size() != 0 || busy)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_near_limit(input logic [THR_W-1:0] value);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      near_limit = value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // Driver: present the oldest pending transaction, hold it until taken
   always @(posedge clock) begin : lookup_driver
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            lookup_expect.insert(lookup_expect.size(), weld_lookup(offered));
            void'(pending_lookups.pop_front());
         end
         if (!(start && busy)) begin
            if (pending_lookups.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               offered = pending_lookups[0];
               start       <= 1'b1;
               req_kind    <= offered.kind;
               req_point_x <= offered.x;
               req_point_y <= offered.y;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result with the oldest prediction
   always @(posedge clock) begin : result_monitor
      lookup_rsp_type want;
      if (!reset && rsp_valid) begin
         if (lookup_expect.size() == 0) begin
            $error("unexpected result: vertex_index %0d", rsp_vertex_index);
            fail_count++;
         end else begin
            want = lookup_expect.pop_front();
            if (rsp_vertex_index !== want.index) begin
               $error("vertex_index: expected %0d, actual %0d", want.index, rsp_vertex_index);
               fail_count++;
            end
            if (rsp_was_found !== want.found) begin
               $error("was_found: expected %0d, actual %0d", want.found, rsp_was_found);
               fail_count++;
            end
            if (rsp_table_full !== want.full) begin
               $error("table_full: expected %0d, actual %0d", want.full, rsp_table_full);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** vertex_dedup_table: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus sequence
   initial begin : stimulus
      logic [63:0] w;
      int k;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      idle_pct = 34;

      // Directed, at the reset distance limit
      push_find(48'd0, 48'd0);
      push_find(48'd0, 48'd0);                       // exact repeat
      push_find(48'd65, 48'd0);                      // just inside the limit
      push_find(48'd66, 48'd0);                      // just outside, appended
      push_find(48'd46, -48'd46);                    // diagonal, inside
      push_find(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
      push_find(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF);
      push_find(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
      push_find(48'h8000_0000_0000, 48'h8000_0000_0000);
      push_find(48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF);
      push_clear('1, '1);
      push_find(48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF);
      push_find('1, '1);
      push_find(48'd0, '1);                          // one unit from the last vertex
      push_find(48'h0F_FFFF, '1);
      push_clear('0, '0);
      push_find(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
      push_find(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
      wait_idle();

      // Zero limit: nothing matches, the table fills and overflows
      write_near_limit('0);
      push_clear(rand48(), rand48());
      gen_lookups(300, 0, 40);
      wait_idle();

      // Widest limit: full table first, then the 2^20 cutoff from a clean table
      write_near_limit(THR_MAX);
      gen_lookups(150, 0, 70);
      push_clear('1, '1);
      push_find(48'd0, 48'd0);
      push_find(48'h0F_FFFF, 48'd0);
      push_find(48'h10_0000, 48'd0);
      push_find(48'd0, -48'h0F_FFFF);
      push_find(48'h0F_FFFF, 48'h0F_FFFF);
      gen_lookups(100, 2, 70);
      wait_idle();

      idle_pct = 48;
      write_near_limit(THR_RESET);
      gen_lookups(250, 2, 60);
      wait_idle();

      write_near_limit(40'h01_0000_0000);
      gen_lookups(250, 2, 60);
      wait_idle();

      // Random limits, sender never idles
      idle_pct = 0;
      for (k = 0; k < 3; k++) begin
         w = {$urandom, $urandom};
         write_near_limit(w[THR_W-1:0] >> $urandom_range(0, THR_W - 1));
         gen_lookups(100, 3, 60);
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && lookup_expect.size() == 0) begin
         $display("** vertex_dedup_table: PASSED **");
      end else begin
         $display("** vertex_dedup_table: FAILED **");
      end
      $finish;
   end

endmodule

// ===== vertex_dedup_table.f =====
design/vdt_pkg.sv
design/vdt_cell.sv
design/vdt_near.sv
design/vertex_dedup_table.sv
test/vertex_dedup_table_test.sv
